/* sv/multi_task_priority_message_queues_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the message queue block
// Clocked concurrent checks, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef MULTI_TASK_PRIORITY_MESSAGE_QUEUES_ASSERT_SVH
`define MULTI_TASK_PRIORITY_MESSAGE_QUEUES_ASSERT_SVH
`ifndef ASSERT_OFF
`define MTPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MTPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MTPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define MTPQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* sv/mtpq_pkg.sv */
// ----------------------------------------------------------------------------
// mtpq_pkg
// Shared types and codes of the multi-task priority message queues.
// ----------------------------------------------------------------------------
`default_nettype none
package mtpq_pkg;

    localparam logic [1:0] FUNC_SEND  = 2'd0;
    localparam logic [1:0] FUNC_FEED  = 2'd1;
    localparam logic [1:0] FUNC_RECV  = 2'd2;
    localparam logic [1:0] FUNC_FETCH = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    localparam logic [1:0] PRIO_INVALID = 2'd3;

    localparam logic [1:0] CFG_ENABLE   = 2'd0;
    localparam logic [1:0] CFG_SEND_CAP = 2'd1;
    localparam logic [1:0] CFG_RECV_CAP = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_PTR,
        S_MSG,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               resp;
        logic [1:0]         prio;
        logic [3:0]         rcv;
        logic [3:0]         snd;
        logic [31:0]        arg;
        logic signed [31:0] code;
    } t_msg;

endpackage
`default_nettype wire

/* sv/multi_task_priority_message_queues.sv */
// ----------------------------------------------------------------------------
// multi_task_priority_message_queues
// Per-task send and receive message queues at three priorities.
// ----------------------------------------------------------------------------
// Each request steps through accept, decode and pointer read, pointer update
// with message store access, message capture on a pop, then hand-off to the
// output register; an error or a miss skips the pointer and message steps.
// The message store is a single-port memory with at most one access per request;
// the per-queue pointer table is read at most once and written back at most once.
// A finished result sits in the output register while the next item is taken.
// Non-empty flags in flip-flops drive the receive and fetch searches; the
// pointer table needs no clearing pass after reset.
`default_nettype none
`include "multi_task_priority_message_queues_assert.svh"
module multi_task_priority_message_queues #(
    parameter int TASKS       = 16,
    parameter int QUEUE_DEPTH = 64
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire  [1:0]         i_func,
    input  wire  [3:0]         i_sender_task,
    input  wire  [3:0]         i_receiver_task,
    input  wire  signed [31:0] i_msg_code,
    input  wire  [31:0]        i_msg_arg,
    input  wire  [1:0]         i_msg_priority,
    input  wire                i_msg_response,
    output logic               o_valid,
    input  wire                i_stall,
    output logic [1:0]         o_status,
    output logic [3:0]         o_out_sender,
    output logic [3:0]         o_out_receiver,
    output logic signed [31:0] o_out_code,
    output logic [31:0]        o_out_arg,
    output logic [1:0]         o_out_priority,
    output logic               o_out_response,
    output logic [3:0]         o_served_task,
    output logic [12:0]        o_total_pending,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire  [1:0]         i_cfg_index,
    input  wire  [15:0]        i_cfg_data
);

    localparam int NQ   = TASKS * 6;
    localparam int QW   = $clog2(NQ);
    localparam int PW   = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int MD   = NQ * QUEUE_DEPTH;
    localparam int AW   = $clog2(MD);
    localparam int TW   = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int TOTW = $clog2(MD + 1);

    typedef struct packed {
        logic [PW-1:0] wp;
        logic [PW-1:0] rp;
        logic [CW-1:0] cnt;
    } t_ptr;

    mtpq_pkg::t_state r_state, n_state;

    // configuration
    logic [15:0] r_mask;
    logic [6:0]  r_scap_cfg, r_rcap_cfg;

    // request
    logic [1:0]     r_func;
    mtpq_pkg::t_msg r_req;

    // queue control
    logic [NQ-1:0]   r_ne;
    logic [NQ-1:0]   r_pv;
    logic [TW-1:0]   r_scan;
    logic [TOTW-1:0] r_pend;
    logic [QW-1:0]   r_q;
    logic            r_pop;
    logic            r_dir;
    logic            r_pv_rd;
    logic [3:0]      r_served;
    logic [1:0]      r_status;
    mtpq_pkg::t_msg  r_msg;

    t_ptr r_ptr_mem [NQ];
    t_ptr r_ptr_rd;

    // output register
    logic            r_ovalid;
    logic [1:0]      r_ostatus;
    mtpq_pkg::t_msg  r_omsg;
    logic [3:0]      r_oserved;
    logic [12:0]     r_opend;

    // ---------------------------------------------------------------- decode
    logic [CW-1:0] scap, rcap, cap;

    function automatic logic [CW-1:0] eff_cap(input logic [6:0] c);
        int v;
        v = int'(c);
        if (v == 0) v = 1;
        else if (v > QUEUE_DEPTH) v = QUEUE_DEPTH;
        return CW'(v);
    endfunction

    function automatic logic [PW-1:0] step_ptr(input logic [PW-1:0] p,
                                               input logic [CW-1:0] c);
        logic [CW:0] n;
        n = (CW+1)'(p) + 1'b1;
        return (n >= (CW+1)'(c)) ? '0 : PW'(n);
    endfunction

    assign scap = eff_cap(r_scap_cfg);
    assign rcap = eff_cap(r_rcap_cfg);
    assign cap  = r_dir ? rcap : scap;

    logic        d_err, d_miss, d_pop, d_dir;
    logic [QW-1:0] d_q;
    logic [3:0]  d_task;
    logic [TW-1:0] d_hit_t;
    logic        d_hit;

    always_comb begin
        d_err   = 1'b0;
        d_miss  = 1'b0;
        d_pop   = 1'b0;
        d_dir   = 1'b0;
        d_q     = '0;
        d_task  = '0;
        d_hit   = 1'b0;
        d_hit_t = '0;
        case (r_func)
            mtpq_pkg::FUNC_SEND, mtpq_pkg::FUNC_FEED: begin
                d_dir  = (r_func == mtpq_pkg::FUNC_FEED);
                d_task = d_dir ? r_req.rcv : r_req.snd;
                d_err  = (r_req.prio == mtpq_pkg::PRIO_INVALID) || (int'(d_task) >= TASKS);
                d_q    = QW'(int'(d_task) * 6 + (d_dir ? 3 : 0) + int'(r_req.prio));
            end
            mtpq_pkg::FUNC_RECV: begin
                d_dir  = 1'b1;
                d_pop  = 1'b1;
                d_task = r_req.rcv;
                d_err  = (int'(d_task) >= TASKS);
                d_miss = 1'b1;
                if (!d_err) begin
                    for (int p = 2; p >= 0; p--) begin
                        if (r_ne[QW'(int'(d_task) * 6 + 3 + p)]) begin
                            d_miss = 1'b0;
                            d_q    = QW'(int'(d_task) * 6 + 3 + p);
                        end
                    end
                end
            end
            default: begin
                // fetch: strict priority first, then lowest task from the scan pointer
                d_pop = 1'b1;
                for (int p = 2; p >= 0; p--) begin
                    for (int t = TASKS - 1; t >= 0; t--) begin
                        if (t < 16 && t >= int'(r_scan) && r_mask[4'(t)]
                                && r_ne[QW'(t * 6 + p)]) begin
                            d_hit   = 1'b1;
                            d_hit_t = TW'(t);
                            d_q     = QW'(t * 6 + p);
                        end
                    end
                end
                d_miss = !d_hit;
                d_task = 4'(d_hit_t);
            end
        endcase
    end

    // ---------------------------------------------------------- pointer table
    t_ptr pd;
    assign pd = r_pv_rd ? r_ptr_rd : '0;

    logic ptr_re, ptr_we, msg_we, msg_re;
    t_ptr ptr_wdata;
    logic [AW-1:0] msg_addr;
    mtpq_pkg::t_msg msg_rdata;

    logic [QW-1:0] r_q_next;
    assign r_q_next = d_q;

    always_ff @(posedge i_clk) begin
        if (ptr_re) begin
            r_ptr_rd <= r_ptr_mem[r_q_next];
        end
        if (ptr_we) begin
            r_ptr_mem[r_q] <= ptr_wdata;
        end
    end

    // ------------------------------------------------------------ next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mtpq_pkg::S_IDLE: if (i_valid) n_state = mtpq_pkg::S_DEC;
            mtpq_pkg::S_DEC:  n_state = (d_err || d_miss) ? mtpq_pkg::S_DONE
                                                          : mtpq_pkg::S_PTR;
            mtpq_pkg::S_PTR:  n_state = r_pop ? mtpq_pkg::S_MSG : mtpq_pkg::S_DONE;
            mtpq_pkg::S_MSG:  n_state = mtpq_pkg::S_DONE;
            mtpq_pkg::S_DONE: if (!r_ovalid || !i_stall) n_state = mtpq_pkg::S_IDLE;
            default:          n_state = mtpq_pkg::S_IDLE;
        endcase
    end

    // --------------------------------------------------------------- outputs
    logic full;
    assign full = (pd.cnt >= cap);

    always_comb begin
        ptr_re    = 1'b0;
        ptr_we    = 1'b0;
        msg_we    = 1'b0;
        msg_re    = 1'b0;
        ptr_wdata = pd;
        msg_addr  = AW'(int'(r_q) * QUEUE_DEPTH + int'(r_pop ? pd.rp : pd.wp));
        case (r_state)
            mtpq_pkg::S_DEC: ptr_re = !(d_err || d_miss);
            mtpq_pkg::S_PTR: begin
                if (r_pop) begin
                    msg_re       = 1'b1;
                    ptr_we       = 1'b1;
                    ptr_wdata.rp = step_ptr(pd.rp, cap);
                    ptr_wdata.cnt = pd.cnt - 1'b1;
                end else if (!full) begin
                    msg_we       = 1'b1;
                    ptr_we       = 1'b1;
                    ptr_wdata.wp = step_ptr(pd.wp, cap);
                    ptr_wdata.cnt = pd.cnt + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    mtpq_msg_ram #(
        .DEPTH (MD),
        .AW    (AW)
    ) u_msg_ram (
        .i_clk   (i_clk),
        .i_we    (msg_we),
        .i_re    (msg_re),
        .i_addr  (msg_addr),
        .i_wdata (r_req),
        .o_rdata (msg_rdata)
    );

    // -------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mtpq_pkg::S_IDLE;
            r_mask     <= '0;
            r_scap_cfg <= 7'd64;
            r_rcap_cfg <= 7'd64;
            r_ne       <= '0;
            r_pv       <= '0;
            r_scan     <= '0;
            r_pend     <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    mtpq_pkg::CFG_ENABLE:   r_mask     <= i_cfg_data;
                    mtpq_pkg::CFG_SEND_CAP: r_scap_cfg <= i_cfg_data[6:0];
                    mtpq_pkg::CFG_RECV_CAP: r_rcap_cfg <= i_cfg_data[6:0];
                    default: begin
                    end
                endcase
            end
            if (r_state == mtpq_pkg::S_DEC && r_func == mtpq_pkg::FUNC_FETCH) begin
                if (d_hit) r_scan <= d_hit_t;
                else       r_scan <= (int'(r_scan) == TASKS - 1) ? '0 : r_scan + 1'b1;
            end
            if (ptr_we) begin
                r_pv[r_q] <= 1'b1;
                r_ne[r_q] <= (ptr_wdata.cnt != '0);
                if (r_pop) begin
                    if (r_pend != '0) r_pend <= r_pend - 1'b1;
                end else begin
                    r_pend <= r_pend + 1'b1;
                end
            end
            if (r_state == mtpq_pkg::S_DONE && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            mtpq_pkg::S_IDLE: begin
                r_func      <= i_func;
                r_req.snd   <= i_sender_task;
                r_req.rcv   <= i_receiver_task;
                r_req.code  <= i_msg_code;
                r_req.arg   <= i_msg_arg;
                r_req.prio  <= i_msg_priority;
                r_req.resp  <= i_msg_response;
            end
            mtpq_pkg::S_DEC: begin
                r_q      <= d_q;
                r_pop    <= d_pop;
                r_dir    <= d_dir;
                r_pv_rd  <= r_pv[d_q];
                r_served <= (d_pop && !d_err && !d_miss) ? d_task : 4'd0;
                r_msg    <= '0;
                r_status <= d_err ? mtpq_pkg::ST_INVALID
                          : d_miss ? mtpq_pkg::ST_EMPTY : mtpq_pkg::ST_OK;
            end
            mtpq_pkg::S_PTR: begin
                if (!r_pop && full) r_status <= mtpq_pkg::ST_FULL;
            end
            mtpq_pkg::S_MSG: r_msg <= msg_rdata;
            mtpq_pkg::S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    r_ostatus <= r_status;
                    r_omsg    <= r_msg;
                    r_oserved <= r_served;
                    r_opend   <= 13'(r_pend);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_stall         = (r_state != mtpq_pkg::S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_out_sender    = r_omsg.snd;
    assign o_out_receiver  = r_omsg.rcv;
    assign o_out_code      = r_omsg.code;
    assign o_out_arg       = r_omsg.arg;
    assign o_out_priority  = r_omsg.prio;
    assign o_out_response  = r_omsg.resp;
    assign o_served_task   = r_oserved;
    assign o_total_pending = r_opend;

    // ------------------------------------------------------------ assertions
    `MTPQ_ASSERT(a_pend_nonzero, i_clk, i_rst_n, (|r_ne) |-> (r_pend != '0), "pending count lost")
    `MTPQ_ASSERT(a_out_from_done, i_clk, i_rst_n, $rose(r_ovalid) |-> ($past(r_state) == mtpq_pkg::S_DONE), "result without completion")
    `MTPQ_ASSERT(a_err_no_msg, i_clk, i_rst_n, (r_ovalid && r_ostatus != mtpq_pkg::ST_OK) |-> (r_oserved == 4'd0 && r_omsg == '0), "error result carries a message")
    `MTPQ_ASSERT(a_ne_needs_pv, i_clk, i_rst_n, ((r_ne & ~r_pv) == '0), "non-empty queue without pointer entry")

endmodule
`default_nettype wire

/* sv/mtpq_msg_ram.sv */
// ----------------------------------------------------------------------------
// mtpq_msg_ram
// Single-port message store with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module mtpq_msg_ram #(
    parameter int DEPTH = 6144,
    parameter int AW    = 13
) (
    input  wire              i_clk,
    input  wire              i_we,
    input  wire              i_re,
    input  wire [AW-1:0]     i_addr,
    input  mtpq_pkg::t_msg   i_wdata,
    output mtpq_pkg::t_msg   o_rdata
);

    mtpq_pkg::t_msg r_mem [DEPTH];
    mtpq_pkg::t_msg r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* bench/multi_task_priority_message_queues_tb.sv */
// ----------------------------------------------------------------------------
// multi_task_priority_message_queues_tb
// Drives send, feed, receive and fetch requests through the message queues,
// predicts every result with a behavioural copy of the queues and compares
// each returned item in all its fields at once, under random idling and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module multi_task_priority_message_queues_tb;

    localparam int NT = 16;
    localparam int QD = 64;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  snd;
        logic [3:0]  rcv;
        logic [31:0] code;
        logic [31:0] arg;
        logic [1:0]  prio;
        logic        resp;
        logic [3:0]  served;
        logic [12:0] pending;
    } t_reply;

    class msg_scoreboard;
        mtpq_pkg::t_msg store [NT*6][QD];
        int unsigned wr_ptr [NT*6];
        int unsigned rd_ptr [NT*6];
        int unsigned fill [NT*6];
        int unsigned pending;
        int unsigned scan;
        logic [15:0] enable_mask;
        logic [6:0]  send_cap;
        logic [6:0]  recv_cap;
        t_reply      replies [$];
        int          mismatches;

        function new();
            for (int q = 0; q < NT*6; q++) begin
                wr_ptr[q] = 0; rd_ptr[q] = 0; fill[q] = 0;
            end
            pending = 0; scan = 0; enable_mask = '0;
            send_cap = 7'd64; recv_cap = 7'd64; mismatches = 0;
        endfunction

        function int unsigned eff(logic [6:0] c);
            if (c == 0) return 1;
            if (c > QD) return QD;
            return int'(c);
        endfunction

        function void pop(int unsigned q, int unsigned cap, ref t_reply r);
            mtpq_pkg::t_msg m;
            int unsigned rp;
            rp = rd_ptr[q];
            if (rp >= QD) rp = 0;
            m = store[q][rp];
            r.snd = m.snd; r.rcv = m.rcv; r.code = m.code; r.arg = m.arg;
            r.prio = m.prio; r.resp = m.resp;
            rd_ptr[q] = (rp + 1 >= cap) ? 0 : rp + 1;
            fill[q]--;
            if (pending > 0) pending--;
        endfunction

        function void note_request(mtpq_pkg::t_msg m, logic [1:0] fn);
            t_reply      r;
            int unsigned task_no, cap, q, wp;
            bit          found;
            r = '0;
            if (fn == mtpq_pkg::FUNC_SEND || fn == mtpq_pkg::FUNC_FEED) begin
                task_no = (fn == mtpq_pkg::FUNC_SEND) ? m.snd : m.rcv;
                cap = (fn == mtpq_pkg::FUNC_SEND) ? eff(send_cap) : eff(recv_cap);
                if (m.prio == mtpq_pkg::PRIO_INVALID) begin
                    r.status = mtpq_pkg::ST_INVALID;
                end else begin
                    q = task_no*6 + ((fn == mtpq_pkg::FUNC_FEED) ? 3 : 0) + m.prio;
                    if (fill[q] >= cap) begin
                        r.status = mtpq_pkg::ST_FULL;
                    end else begin
                        wp = wr_ptr[q];
                        if (wp >= QD) wp = 0;
                        store[q][wp] = m;
                        wr_ptr[q] = (wp + 1 >= cap) ? 0 : wp + 1;
                        fill[q]++;
                        pending++;
                        r.status = mtpq_pkg::ST_OK;
                    end
                end
            end else if (fn == mtpq_pkg::FUNC_RECV) begin
                r.status = mtpq_pkg::ST_EMPTY;
                for (int p = 0; p < 3; p++) begin
                    q = m.rcv*6 + 3 + p;
                    if (fill[q] != 0) begin
                        pop(q, eff(recv_cap), r);
                        r.served = m.rcv;
                        r.status = mtpq_pkg::ST_OK;
                        break;
                    end
                end
            end else begin
                found = 0;
                for (int p = 0; p < 3 && !found; p++) begin
                    for (int t = scan; t < NT; t++) begin
                        q = t*6 + p;
                        if (enable_mask[t] && fill[q] != 0) begin
                            pop(q, eff(send_cap), r);
                            r.served = 4'(t);
                            scan = t;
                            found = 1;
                            break;
                        end
                    end
                end
                if (found) begin
                    r.status = mtpq_pkg::ST_OK;
                end else begin
                    r.status = mtpq_pkg::ST_EMPTY;
                    scan = (scan + 1) % NT;
                end
            end
            r.pending = 13'(pending);
            replies.push_back(r);
        endfunction

        function void check_reply(t_reply got);
            t_reply want;
            if (replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item %p", got);
                return;
            end
            want = replies.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
        endfunction
    endclass

    logic        i_clk = 0, i_rst_n = 0;
    logic        i_valid = 0, i_stall = 0;
    logic [1:0]  i_func = '0;
    logic [3:0]  i_sender_task = '0, i_receiver_task = '0;
    logic [31:0] i_msg_code = '0, i_msg_arg = '0;
    logic [1:0]  i_msg_priority = '0;
    logic        i_msg_response = 0;
    logic        i_cfg_valid = 0;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    wire         o_stall, o_valid, o_cfg_ready, o_out_response;
    wire [1:0]   o_status, o_out_priority;
    wire [3:0]   o_out_sender, o_out_receiver, o_served_task;
    wire [31:0]  o_out_code, o_out_arg;
    wire [12:0]  o_total_pending;

    multi_task_priority_message_queues u_top (.*);

    always #5 i_clk = ~i_clk;

    msg_scoreboard sb = new();
    bit quiet = 0;      // no idling in the last part
    bit hold_off = 0;   // long receiver stall request
    bit done = 0;

    // receiver side: random stall bursts, one long hold-off on request
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_stall <= 1;
                repeat (300) @(posedge i_clk);
                i_stall <= 0;
                hold_off = 0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 9);
                i_stall <= 1;
                repeat (n) @(posedge i_clk);
                i_stall <= 0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_reply('{o_status, o_out_sender, o_out_receiver, o_out_code, o_out_arg,
                             o_out_priority, o_out_response, o_served_task,
                             o_total_pending});
    end

    // valid stays high after an accepted item until the next item or an idle
    // gap replaces it, so that it is never assigned twice at one edge
    task automatic send_item(logic [1:0] fn, logic [3:0] s, logic [3:0] r,
                             logic [31:0] c, logic [31:0] a, logic [1:0] p, logic rs);
        mtpq_pkg::t_msg m;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid <= 1; i_func <= fn; i_sender_task <= s; i_receiver_task <= r;
        i_msg_code <= c; i_msg_arg <= a; i_msg_priority <= p; i_msg_response <= rs;
        do @(posedge i_clk); while (o_stall);
        m.snd = s; m.rcv = r; m.code = c; m.arg = a; m.prio = p; m.resp = rs;
        sb.note_request(m, fn);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.replies.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        @(posedge i_clk);
        if (idx == mtpq_pkg::CFG_ENABLE) sb.enable_mask = val;
        else if (idx == mtpq_pkg::CFG_SEND_CAP) sb.send_cap = val[6:0];
        else sb.recv_cap = val[6:0];
    endtask

    task automatic random_item(int tasks_hi);
        logic [1:0] fn;
        logic [1:0] p;
        fn = 2'($urandom_range(0, 3));
        p = ($urandom_range(0, 15) == 0) ? mtpq_pkg::PRIO_INVALID : 2'($urandom_range(0, 2));
        send_item(fn, 4'($urandom_range(0, tasks_hi)), 4'($urandom_range(0, tasks_hi)),
                  $urandom, $urandom, p, 1'($urandom_range(0, 1)));
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: fetch with all disabled, extremes, invalid priority
        send_item(mtpq_pkg::FUNC_FETCH, 0, 0, 0, 0, 0, 0);
        send_item(mtpq_pkg::FUNC_RECV, 0, 15, 0, 0, 0, 0);
        send_item(mtpq_pkg::FUNC_SEND, 15, 0, 32'h8000_0000, 32'hFFFF_FFFF, 2, 1);
        send_item(mtpq_pkg::FUNC_SEND, 0, 15, 32'h7FFF_FFFF, 32'h0, 0, 0);
        send_item(mtpq_pkg::FUNC_SEND, 3, 4, 1, 2, mtpq_pkg::PRIO_INVALID, 1);
        send_item(mtpq_pkg::FUNC_FEED, 1, 15, 32'hFFFF_FFFF, 32'h1234_5678, 1, 1);
        send_item(mtpq_pkg::FUNC_FEED, 2, 15, 5, 6, 0, 0);
        send_item(mtpq_pkg::FUNC_FEED, 2, 15, 5, 6, mtpq_pkg::PRIO_INVALID, 0);
        send_item(mtpq_pkg::FUNC_RECV, 0, 15, 0, 0, 0, 0);
        send_item(mtpq_pkg::FUNC_RECV, 0, 15, 0, 0, 0, 0);
        send_item(mtpq_pkg::FUNC_RECV, 0, 15, 0, 0, 0, 0);
        send_item(mtpq_pkg::FUNC_FETCH, 0, 0, 0, 0, 0, 0);
        drain();
        write_reg(mtpq_pkg::CFG_ENABLE, 16'hFFFF);
        write_reg(mtpq_pkg::CFG_SEND_CAP, 16'd0);
        write_reg(mtpq_pkg::CFG_RECV_CAP, 16'd1);
        send_item(mtpq_pkg::FUNC_SEND, 7, 1, 9, 9, 1, 0);
        send_item(mtpq_pkg::FUNC_SEND, 7, 1, 9, 9, 1, 0);   // full at capacity one
        send_item(mtpq_pkg::FUNC_FEED, 7, 1, 9, 9, 2, 1);
        send_item(mtpq_pkg::FUNC_FEED, 7, 1, 9, 9, 2, 1);
        for (int k = 0; k < 4; k++) send_item(mtpq_pkg::FUNC_FETCH, 0, 0, 0, 0, 0, 0);
        drain();
        // random phases over several settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(mtpq_pkg::CFG_SEND_CAP, 16'd64);
                    write_reg(mtpq_pkg::CFG_RECV_CAP, 16'd64);
                end
                1: begin
                    write_reg(mtpq_pkg::CFG_SEND_CAP, 16'd3);
                    write_reg(mtpq_pkg::CFG_RECV_CAP, 16'd2);
                end
                2: begin
                    write_reg(mtpq_pkg::CFG_ENABLE, 16'($urandom));
                    write_reg(mtpq_pkg::CFG_SEND_CAP, 16'd127);
                end
                3: begin
                    write_reg(mtpq_pkg::CFG_ENABLE, 16'h0000);
                    write_reg(mtpq_pkg::CFG_RECV_CAP, 16'd5);
                end
                4: begin
                    write_reg(mtpq_pkg::CFG_ENABLE, 16'hA5C3);
                    write_reg(mtpq_pkg::CFG_SEND_CAP, 16'd2);
                end
                default: begin
                    write_reg(mtpq_pkg::CFG_ENABLE, 16'hFFFF);
                    write_reg(mtpq_pkg::CFG_RECV_CAP, 16'd4);
                end
            endcase
            if (ph == 1) hold_off = 1;
            if (ph == 5) quiet = 1;
            for (int k = 0; k < 110; k++) random_item((ph % 2) ? 3 : 15);
            drain();   // sender waits for every result
        end
        done = 1;
    end

    initial begin
        wait (done);
        if (sb.mismatches == 0 && sb.replies.size() == 0) begin
            $display("multi_task_priority_message_queues_tb: clean");
        end else begin
            $display("multi_task_priority_message_queues_tb: errors");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("multi_task_priority_message_queues_tb: errors");
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
+incdir+sv
sv/mtpq_pkg.sv
sv/mtpq_msg_ram.sv
sv/multi_task_priority_message_queues.sv
bench/multi_task_priority_message_queues_tb.sv
